// File: src/assert_macros.svh
// assertion macros for the pixel buffer range engine
// expects clk and rst (synchronous, active high) in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/lpbre_pkg.sv
// shared types and constants of the pixel buffer range engine
// no dependencies
package lpbre_pkg;

  localparam int PIXELS = 64;
  localparam int IDX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // command codes
  localparam logic [2:0] REQ_WRITE     = 3'd0;
  localparam logic [2:0] REQ_FILL      = 3'd1;
  localparam logic [2:0] REQ_ADD       = 3'd2;
  localparam logic [2:0] REQ_ROT_LEFT  = 3'd3;
  localparam logic [2:0] REQ_ROT_RIGHT = 3'd4;
  localparam logic [2:0] REQ_READ      = 3'd5;

  localparam logic STATUS_ACK = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] first_index;
    logic [7:0] last_index;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
  } request_t;

  typedef struct packed {
    logic       status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_SCAN,
    ST_LAST
  } state_t;

endpackage

// File: src/led_pixel_buffer_range_engine_top.sv
// top level of the pixel buffer range engine: command sequencer around the pixel memory
// depends on lpbre_pkg and assert_macros.svh
//
// usage
//   a command beat is taken at a rising edge with start high and busy low.
//   every command gives exactly one result beat on result, marked by done
//   for one cycle; the receiver cannot stall, so results are never held.
//   write pixel and any rejected command are answered straight from idle;
//   read pixel passes through ST_READ; fill walks the range in ST_FILL;
//   add walks it in ST_SCAN; rotate left or right walks it in ST_SCAN and
//   then writes the saved end pixel back in ST_LAST.
//   busy stays high until the result beat is issued; the next command can be
//   taken in the cycle that done is high. one pixel moves per cycle, set by
//   the single write port of the pixel memory, so the run of a range command
//   grows with the length of its range.
//   reset clears the sequencer and one valid flag per pixel; a pixel whose
//   flag is clear reads as black, so the store is all zero right after reset
//   with no clearing pass.
module led_pixel_buffer_range_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lpbre_pkg::request_t request,
  output logic               done,
  output lpbre_pkg::result_t result
);

  `include "assert_macros.svh"

  localparam int IDX_W = lpbre_pkg::IDX_W;

  // pixel memory and valid flags
  lpbre_pkg::pixel_t mem [lpbre_pkg::PIXELS];
  logic [lpbre_pkg::PIXELS-1:0] valid;
  lpbre_pkg::pixel_t rd_data;
  logic              rd_valid;

  // sequencer registers
  lpbre_pkg::state_t   state, state_next;
  lpbre_pkg::request_t cmd, cmd_next;
  logic [IDX_W-1:0]    data_addr, data_addr_next;
  lpbre_pkg::pixel_t   tmp, tmp_next;
  logic                done_next;
  lpbre_pkg::result_t  result_next;

  // memory access controls
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  lpbre_pkg::pixel_t wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_issue;

  // decoded input checks
  logic              first_ok, last_ok, range_ok;
  logic [IDX_W-1:0]  in_first, in_last, cmd_first, cmd_last;
  lpbre_pkg::pixel_t pix, cmd_color, sum;

  assign first_ok  = int'(request.first_index) < lpbre_pkg::PIXELS;
  assign last_ok   = int'(request.last_index) < lpbre_pkg::PIXELS;
  assign range_ok  = first_ok && last_ok && (request.last_index >= request.first_index);
  assign in_first  = request.first_index[IDX_W-1:0];
  assign in_last   = request.last_index[IDX_W-1:0];
  assign cmd_first = cmd.first_index[IDX_W-1:0];
  assign cmd_last  = cmd.last_index[IDX_W-1:0];
  assign cmd_color = '{red: cmd.red_value, green: cmd.green_value, blue: cmd.blue_value};

  // pixel as stored, black when never written
  assign pix = rd_valid ? rd_data : '0;

  // per-channel add with wrap
  assign sum.red   = pix.red + cmd.red_value;
  assign sum.green = pix.green + cmd.green_value;
  assign sum.blue  = pix.blue + cmd.blue_value;

  assign busy = (state != lpbre_pkg::ST_IDLE);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // valid flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpbre_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    cmd       <= cmd_next;
    data_addr <= data_addr_next;
    tmp       <= tmp_next;
    result    <= result_next;
  end

  // next state, memory controls and result
  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    data_addr_next = data_addr;
    tmp_next       = tmp;
    done_next      = 1'b0;
    result_next    = result;
    wr_en          = 1'b0;
    wr_addr        = data_addr;
    wr_data        = cmd_color;
    rd_addr        = data_addr;
    rd_issue       = 1'b0;

    unique case (state)
      lpbre_pkg::ST_IDLE: begin
        if (start) begin
          cmd_next    = request;
          result_next = '{status: lpbre_pkg::STATUS_ERR, default: '0};
          unique case (request.req_type) inside
            lpbre_pkg::REQ_WRITE: begin
              wr_en              = first_ok;
              wr_addr            = in_first;
              wr_data            = '{red: request.red_value, green: request.green_value,
                                     blue: request.blue_value};
              result_next.status = lpbre_pkg::STATUS_ACK;
              done_next          = 1'b1;
            end
            lpbre_pkg::REQ_READ: begin
              if (first_ok) begin
                rd_addr        = in_first;
                rd_issue       = 1'b1;
                data_addr_next = in_first;
                state_next     = lpbre_pkg::ST_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            lpbre_pkg::REQ_FILL: begin
              if (range_ok) begin
                data_addr_next = in_first;
                state_next     = lpbre_pkg::ST_FILL;
              end else begin
                done_next = 1'b1;
              end
            end
            lpbre_pkg::REQ_ADD, lpbre_pkg::REQ_ROT_LEFT: begin
              if (range_ok) begin
                rd_addr        = in_first;
                rd_issue       = 1'b1;
                data_addr_next = in_first;
                state_next     = lpbre_pkg::ST_SCAN;
              end else begin
                done_next = 1'b1;
              end
            end
            lpbre_pkg::REQ_ROT_RIGHT: begin
              if (range_ok) begin
                rd_addr        = in_last;
                rd_issue       = 1'b1;
                data_addr_next = in_last;
                state_next     = lpbre_pkg::ST_SCAN;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // read data arrives, return it
      lpbre_pkg::ST_READ: begin
        result_next = '{status: lpbre_pkg::STATUS_ACK, red_out: pix.red,
                        green_out: pix.green, blue_out: pix.blue};
        done_next   = 1'b1;
        state_next  = lpbre_pkg::ST_IDLE;
      end

      // one pixel of the fill per cycle
      lpbre_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = data_addr;
        wr_data = cmd_color;
        if (data_addr == cmd_last) begin
          result_next = '{status: lpbre_pkg::STATUS_ACK, default: '0};
          done_next   = 1'b1;
          state_next  = lpbre_pkg::ST_IDLE;
        end else begin
          data_addr_next = data_addr + 1'b1;
        end
      end

      // streamed read-modify-write, next read issued while this beat writes back
      lpbre_pkg::ST_SCAN: begin
        case (cmd.req_type)
          lpbre_pkg::REQ_ADD: begin
            wr_en   = 1'b1;
            wr_addr = data_addr;
            wr_data = sum;
            if (data_addr == cmd_last) begin
              result_next = '{status: lpbre_pkg::STATUS_ACK, default: '0};
              done_next   = 1'b1;
              state_next  = lpbre_pkg::ST_IDLE;
            end else begin
              rd_addr        = data_addr + 1'b1;
              rd_issue       = 1'b1;
              data_addr_next = rd_addr;
            end
          end
          lpbre_pkg::REQ_ROT_LEFT: begin
            if (data_addr == cmd_first) begin
              tmp_next = pix;
            end else begin
              wr_en   = 1'b1;
              wr_addr = data_addr - 1'b1;
              wr_data = pix;
            end
            if (data_addr == cmd_last) begin
              state_next = lpbre_pkg::ST_LAST;
            end else begin
              rd_addr        = data_addr + 1'b1;
              rd_issue       = 1'b1;
              data_addr_next = rd_addr;
            end
          end
          default: begin
            // rotate right walks downward from the last pixel
            if (data_addr == cmd_last) begin
              tmp_next = pix;
            end else begin
              wr_en   = 1'b1;
              wr_addr = data_addr + 1'b1;
              wr_data = pix;
            end
            if (data_addr == cmd_first) begin
              state_next = lpbre_pkg::ST_LAST;
            end else begin
              rd_addr        = data_addr - 1'b1;
              rd_issue       = 1'b1;
              data_addr_next = rd_addr;
            end
          end
        endcase
      end

      // saved end pixel goes to the far end of the range
      lpbre_pkg::ST_LAST: begin
        wr_en       = 1'b1;
        wr_addr     = (cmd.req_type == lpbre_pkg::REQ_ROT_LEFT) ? cmd_last : cmd_first;
        wr_data     = tmp;
        result_next = '{status: lpbre_pkg::STATUS_ACK, default: '0};
        done_next   = 1'b1;
        state_next  = lpbre_pkg::ST_IDLE;
      end

      default: begin
        state_next = lpbre_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  `ASSERT_IMPL(a_done_idle, done, !busy)
  `ASSERT_NEXT(a_write_one_cycle, start && !busy && request.req_type == lpbre_pkg::REQ_WRITE, done)
  `ASSERT_IMPL(a_err_black, done && result.status == lpbre_pkg::STATUS_ERR,
               result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0)
  `ASSERT_IMPL(a_no_overlap, state == lpbre_pkg::ST_SCAN && wr_en && rd_issue, wr_addr != rd_addr)

endmodule
